[rtl/sdpq_pkg.sv]
// Shared types, constants and codes of the sorted deadline priority queue.
package sdpq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FLD_W    = 5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_POP    = 3'd1,
    OP_FIND   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_COUNT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_POP,
    CM_REMOVE
  } cell_mode_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] code;
    logic [31:0] key;
    logic [7:0]  prio;
    logic [31:0] payload;
  } entry_t;

  typedef struct packed {
    logic       capture;
    cell_mode_t mode;
    entry_t     item;
  } cell_ctl_t;

endpackage

[rtl/sdpq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts it to or from its neighbors.
module sdpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sdpq_pkg::cell_ctl_t ctl,
  input  sdpq_pkg::entry_t   left_entry,
  input  logic               left_valid,
  input  logic               left_cond,
  input  logic               left_seen,
  input  sdpq_pkg::entry_t   right_entry,
  input  logic               right_valid,
  output sdpq_pkg::entry_t   entry_o,
  output logic               valid_o,
  output logic               cond_o,
  output logic               seen_o,
  output logic               match_o,
  output logic               first_o
);
  import sdpq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   cond_r;
  logic   match_r;
  logic   lt;

  assign lt = (ctl.item.key < entry_r.key) ||
              ((ctl.item.key == entry_r.key) && (ctl.item.prio < entry_r.prio));

  assign seen_o  = left_seen | match_r;
  assign first_o = match_r & ~left_seen;
  assign cond_o  = cond_r;
  assign match_o = match_r;
  assign entry_o = entry_r;
  assign valid_o = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    unique case (ctl.mode)
      CM_INSERT: begin
        if (left_cond) begin
          entry_nxt = left_entry;
          valid_nxt = left_valid;
        end else if (cond_r) begin
          entry_nxt = ctl.item;
          valid_nxt = 1'b1;
        end
      end
      CM_POP: begin
        entry_nxt = right_entry;
        valid_nxt = right_valid;
      end
      CM_REMOVE: begin
        if (seen_o) begin
          entry_nxt = right_entry;
          valid_nxt = right_valid;
        end
      end
      CM_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      cond_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.capture) begin
        cond_r  <= ~valid_r | lt;
        match_r <= valid_r & (ctl.item.id == entry_r.id);
      end
    end
  end

endmodule

[rtl/sorted_deadline_priority_queue.sv]
// Top level of the sorted deadline priority queue: operation control and result register.
//
// The queue holds up to CAPACITY entries sorted by key, then priority; equal
// entries keep their arrival order. Operations arrive on the in_ channel
// (valid/ready): insert, pop head, find by id, remove by id, count by id.
// Every item gives exactly one result on the out_ channel (valid/ready) with
// a status, the entry involved, the match count and the occupancy after it.
// An accepted item is compared against every slot at the accept edge; in S_APPLY
// the chain of slot cells shifts in one step and the result is loaded into the
// output register. in_ready is low in S_APPLY, so a new item is not taken
// until the previous one has been applied. If the previous result is still
// waiting when an item is ready to finish, the shift holds until the receiver
// takes the old result, so a stalled receiver stalls the input after at most
// one further item.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
module sorted_deadline_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_id,
  input  logic [15:0] in_code,
  input  logic [31:0] in_key,
  input  logic [7:0]  in_priority_req,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_id,
  output logic [15:0] out_code,
  output logic [31:0] out_key,
  output logic [7:0]  out_priority,
  output logic [31:0] out_payload,
  output logic [4:0]  out_match_count,
  output logic [4:0]  out_occupancy
);
  import sdpq_pkg::*;

  typedef enum logic {S_IDLE, S_APPLY} state_t;

  state_t    state_r;
  logic [2:0] op_r;
  entry_t    new_r;
  logic [CNT_W-1:0] count_r;
  logic      out_valid_r;
  logic [1:0] status_r, status_nxt;
  entry_t    res_r, res_nxt;
  logic [FLD_W-1:0] mcount_r, mcount_nxt;
  logic [CNT_W-1:0] count_nxt;

  entry_t    in_entry;
  cell_ctl_t ctl;
  cell_mode_t mode;
  logic      accept;
  logic      apply;

  entry_t    ent   [CAPACITY];
  logic [CAPACITY-1:0] vld_vec, cond_vec, seen_vec, match_vec, first_vec;

  entry_t    sel_entry;
  logic      found;
  logic      full;
  logic [CNT_W-1:0] hits;
  logic [CNT_W+FLD_W-1:0] hits_wide, count_wide;

  assign in_entry = '{id: in_id, code: in_code, key: in_key, prio: in_priority_req,
                      payload: in_payload};

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign apply    = (state_r == S_APPLY) & (~out_valid_r | out_ready);
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign found    = seen_vec[CAPACITY-1];
  assign hits     = CNT_W'($countones(match_vec));
  assign hits_wide = {{FLD_W{1'b0}}, hits};

  assign ctl.capture = accept;
  assign ctl.mode    = apply ? mode : CM_HOLD;
  assign ctl.item    = in_ready ? in_entry : new_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, left_c, left_s, right_v;
    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_v = 1'b0;
      assign left_c = 1'b0;
      assign left_s = 1'b0;
    end else begin : g_body
      assign left_e = ent[i-1];
      assign left_v = vld_vec[i-1];
      assign left_c = cond_vec[i-1];
      assign left_s = seen_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_mid
      assign right_e = ent[i+1];
      assign right_v = vld_vec[i+1];
    end
    sdpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .left_cond   (left_c),
      .left_seen   (left_s),
      .right_entry (right_e),
      .right_valid (right_v),
      .entry_o     (ent[i]),
      .valid_o     (vld_vec[i]),
      .cond_o      (cond_vec[i]),
      .seen_o      (seen_vec[i]),
      .match_o     (match_vec[i]),
      .first_o     (first_vec[i])
    );
  end

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_entry = sel_entry | (first_vec[i] ? ent[i] : '0);
    end
  end

  always_comb begin
    mode       = CM_HOLD;
    status_nxt = ST_NONE;
    res_nxt    = '0;
    mcount_nxt = '0;
    count_nxt  = count_r;
    unique case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          mode       = CM_INSERT;
          status_nxt = ST_OK;
          res_nxt    = new_r;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count_r != '0) begin
          mode       = CM_POP;
          status_nxt = ST_OK;
          res_nxt    = ent[0];
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (found) begin
          status_nxt = ST_OK;
          res_nxt    = sel_entry;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          mode       = CM_REMOVE;
          status_nxt = ST_OK;
          res_nxt    = sel_entry;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_COUNT: begin
        status_nxt = ST_OK;
        mcount_nxt = hits_wide[FLD_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      new_r <= in_entry;
    end
    if (apply) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      mcount_r <= mcount_nxt;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_APPLY;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_APPLY: begin
          if (apply) begin
            state_r     <= S_IDLE;
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign count_wide      = {{FLD_W{1'b0}}, count_r};
  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_id          = res_r.id;
  assign out_code        = res_r.code;
  assign out_key         = res_r.key;
  assign out_priority    = res_r.prio;
  assign out_payload     = res_r.payload;
  assign out_match_count = mcount_r;
  assign out_occupancy   = count_wide[FLD_W-1:0];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("Entry count disagrees with the valid slots.");

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_vec & (vld_vec + CAPACITY'(1))) == '0)
    else $error("Valid slots are not packed at the head.");

  a_apply_done: assert property (@(posedge clk) disable iff (!rst_n)
    apply |=> (state_r == S_IDLE) && out_valid_r)
    else $error("A finished item did not reach the output register.");

endmodule

[dv/testbench.sv]
// Testbench of the sorted deadline priority queue: directed and random items checked against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sdpq_pkg::*;

  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;
  localparam int         N_RANDOM   = 600;
  localparam int         DRAIN_WAIT = 20;

  typedef struct packed {
    logic [2:0] op;
    entry_t     ent;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    entry_t     ent;
    logic [4:0] match_count;
    logic [4:0] occupancy;
  } answer_t;

  class queue_checker;
    entry_t      slots[CAPACITY];
    int unsigned held;
    answer_t     pending_answers[$];
    int          errors;
    int          checked;
    int          full_refusals;
    int          misses;

    function void drop_slot(int unsigned idx);
      int unsigned j;
      for (j = idx; j + 1 < held; j++) begin
        slots[j] = slots[j + 1];
      end
      held--;
    endfunction

    function int unsigned first_with_id(logic [15:0] id);
      int unsigned i;
      int unsigned pos;
      pos = held;
      for (i = 0; i < held; i++) begin
        if (pos == held && slots[i].id == id) begin
          pos = i;
        end
      end
      return pos;
    endfunction

    function answer_t apply_queue_op(request_t req);
      answer_t     ans;
      int unsigned i;
      int unsigned pos;
      int unsigned hits;
      ans = '0;
      ans.status = ST_NONE;
      case (req.op)
        OP_INSERT: begin
          if (held >= CAPACITY) begin
            ans.status = ST_FULL;
          end else begin
            pos = held;
            for (i = 0; i < held; i++) begin
              if (pos == held && (req.ent.key < slots[i].key ||
                  (req.ent.key == slots[i].key && req.ent.prio < slots[i].prio))) begin
                pos = i;
              end
            end
            for (i = held; i > pos; i--) begin
              slots[i] = slots[i - 1];
            end
            slots[pos] = req.ent;
            held++;
            ans.status = ST_OK;
            ans.ent = req.ent;
          end
        end
        OP_POP: begin
          if (held > 0) begin
            ans.status = ST_OK;
            ans.ent = slots[0];
            drop_slot(0);
          end
        end
        OP_FIND, OP_REMOVE: begin
          pos = first_with_id(req.ent.id);
          if (pos < held) begin
            ans.status = ST_OK;
            ans.ent = slots[pos];
            if (req.op == OP_REMOVE) begin
              drop_slot(pos);
            end
          end
        end
        OP_COUNT: begin
          hits = 0;
          for (i = 0; i < held; i++) begin
            if (slots[i].id == req.ent.id) begin
              hits++;
            end
          end
          ans.status = ST_OK;
          ans.match_count = 5'(hits);
        end
        default: begin
        end
      endcase
      ans.occupancy = 5'(held);
      return ans;
    endfunction

    function void note_request(request_t req);
      pending_answers.push_back(apply_queue_op(req));
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
        errors++;
      end
    endfunction

    function void check_answer(answer_t act);
      answer_t exp;
      if (pending_answers.size() == 0) begin
        $error("result arrived with nothing expected");
        errors++;
        return;
      end
      exp = pending_answers.pop_front();
      checked++;
      if (exp.status == ST_FULL) full_refusals++;
      if (exp.status == ST_NONE) misses++;
      compare_field("status", 32'(exp.status), 32'(act.status));
      compare_field("out_id", 32'(exp.ent.id), 32'(act.ent.id));
      compare_field("out_code", 32'(exp.ent.code), 32'(act.ent.code));
      compare_field("out_key", exp.ent.key, act.ent.key);
      compare_field("out_priority", 32'(exp.ent.prio), 32'(act.ent.prio));
      compare_field("out_payload", exp.ent.payload, act.ent.payload);
      compare_field("match_count", 32'(exp.match_count), 32'(act.match_count));
      compare_field("occupancy", 32'(exp.occupancy), 32'(act.occupancy));
    endfunction

    function void close_out();
      if (pending_answers.size() != 0) begin
        $error("%0d results never arrived", pending_answers.size());
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [15:0] in_id;
  logic [15:0] in_code;
  logic [31:0] in_key;
  logic [7:0]  in_priority_req;
  logic [31:0] in_payload;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [15:0] out_id;
  logic [15:0] out_code;
  logic [31:0] out_key;
  logic [7:0]  out_priority;
  logic [31:0] out_payload;
  logic [4:0]  out_match_count;
  logic [4:0]  out_occupancy;

  queue_checker scb;
  request_t     directed_q[$];
  int           burst_left;
  int           target_level;
  int           target_left;
  int           sent_items;

  sorted_deadline_priority_queue DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_id           (in_id),
    .in_code         (in_code),
    .in_key          (in_key),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_code        (out_code),
    .out_key         (out_key),
    .out_priority    (out_priority),
    .out_payload     (out_payload),
    .out_match_count (out_match_count),
    .out_occupancy   (out_occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic add_directed(logic [2:0] op, logic [15:0] id, logic [15:0] code,
                              logic [31:0] key, logic [7:0] prio, logic [31:0] payload);
    request_t r;
    r.op = op;
    r.ent.id = id;
    r.ent.code = code;
    r.ent.key = key;
    r.ent.prio = prio;
    r.ent.payload = payload;
    directed_q.push_back(r);
  endtask

  task automatic send_request(request_t r);
    in_valid        <= 1'b1;
    in_op           <= r.op;
    in_id           <= r.ent.id;
    in_code         <= r.ent.code;
    in_key          <= r.ent.key;
    in_priority_req <= r.ent.prio;
    in_payload      <= r.ent.payload;
    do @(posedge clk); while (!in_ready);
    scb.note_request(r);
    sent_items++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 19);
    end
  endtask

  function automatic request_t random_request();
    request_t r;
    int       pick;
    if (target_left == 0) begin
      pick = $urandom_range(0, 2);
      target_level = (pick == 0) ? 0 : (pick == 1) ? CAPACITY : $urandom_range(0, CAPACITY);
      target_left = $urandom_range(20, 60);
    end
    target_left--;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      r.op = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
    end else if ($urandom_range(0, 99) < ((scb.held < target_level) ? 70 : 25)) begin
      r.op = OP_INSERT;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 7) r.op = OP_POP;
      else if (pick < 11) r.op = OP_FIND;
      else if (pick < 16) r.op = OP_REMOVE;
      else r.op = OP_COUNT;
    end
    pick = $urandom_range(0, 9);
    r.ent.id = (pick < 8) ? 16'($urandom_range(0, 5)) :
               (pick == 8) ? {16{$urandom_range(0, 1) == 1}} : 16'($urandom);
    pick = $urandom_range(0, 9);
    r.ent.key = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF :
                (pick < 6) ? 32'($urandom_range(0, 3)) : 32'($urandom);
    pick = $urandom_range(0, 9);
    r.ent.prio = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                 (pick < 6) ? 8'($urandom_range(0, 2)) : 8'($urandom);
    pick = $urandom_range(0, 9);
    r.ent.code = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
    pick = $urandom_range(0, 9);
    r.ent.payload = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
    return r;
  endfunction

  initial begin
    int       i;
    int       real_items;
    request_t r;
    scb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_INSERT;
    in_id = '0;
    in_code = '0;
    in_key = '0;
    in_priority_req = '0;
    in_payload = '0;
    burst_left = 0;
    target_level = 0;
    target_left = 0;
    sent_items = 0;

    add_directed(OP_POP, 16'h0000, 16'h0000, 32'h0, 8'h00, 32'h0);
    add_directed(OP_FIND, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    add_directed(OP_REMOVE, 16'hFFFF, 16'h0000, 32'h0, 8'h00, 32'h0);
    add_directed(OP_COUNT, 16'h0000, 16'h0000, 32'h0, 8'h00, 32'h0);
    add_directed(OP_RSVD_HI, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
    for (i = 0; i < CAPACITY; i++) begin
      add_directed(OP_INSERT, 16'hA5A5, (i % 2 == 1) ? 16'hFFFF : 16'(i),
                   (i % 4 == 0) ? 32'hFFFF_FFFF : (i % 4 == 1) ? 32'h0 : 32'h8000_0000,
                   (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h00 : 8'h80,
                   (i % 2 == 1) ? 32'hFFFF_FFFF : 32'(i));
    end
    add_directed(OP_INSERT, 16'h0000, 16'h1234, 32'h0, 8'h00, 32'h5555_AAAA);
    add_directed(OP_COUNT, 16'hA5A5, 16'h0000, 32'h0, 8'h00, 32'h0);
    add_directed(OP_FIND, 16'hA5A5, 16'h0000, 32'h0, 8'h00, 32'h0);
    add_directed(OP_REMOVE, 16'hA5A5, 16'h0000, 32'h0, 8'h00, 32'h0);
    add_directed(OP_POP, 16'h0000, 16'h0000, 32'h0, 8'h00, 32'h0);
    add_directed(OP_COUNT, 16'hA5A5, 16'h0000, 32'h0, 8'h00, 32'h0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_q[k]) begin
      send_request(directed_q[k]);
    end

    real_items = 0;
    while (real_items < N_RANDOM) begin
      r = random_request();
      if (r.op <= OP_COUNT) real_items++;
      send_request(r);
    end
    in_valid <= 1'b0;

    while (scb.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    scb.close_out();
    $display("Sent %0d items and checked %0d results.", sent_items, scb.checked);
    $display("Results included %0d inserts refused as full and %0d empty or missed lookups.",
             scb.full_refusals, scb.misses);
    if (scb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int  mode;
    int  mode_left;
    int  run_left;
    logic run_ready;
    answer_t act;
    out_ready = 1'b0;
    mode = 0;
    mode_left = 0;
    run_left = 0;
    run_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        act.status = out_status;
        act.ent.id = out_id;
        act.ent.code = out_code;
        act.ent.key = out_key;
        act.ent.prio = out_priority;
        act.ent.payload = out_payload;
        act.match_count = out_match_count;
        act.occupancy = out_occupancy;
        scb.check_answer(act);
      end
      @(negedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (run_left == 0) begin
        run_ready = !run_ready;
        run_left = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 25);
      end
      run_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= run_ready;
        default: out_ready <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  initial begin
    #2_000_000;
    $error("run did not finish in the allotted time");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
